@@ sv/ssrl_pkg.sv @@
// Shared constants for the servo slew-rate limiter.
// Used by servo_slew_rate_limiter; no dependencies.
package ssrl_pkg;

  // parameter defaults
  localparam int CHANNELS_DEF    = 8;
  localparam int VALUE_LIMIT_DEF = 1250;
  localparam int FRAME_US_DEF    = 22500;

  // field widths
  localparam int CH_W      = 3;
  localparam int TGT_W     = 12;
  localparam int DATA_W    = 16;   // channel + target, padded to bytes
  localparam int POS_W     = 16;   // stored position, 1/100 percent
  localparam int SLOTS     = 8;
  localparam int DELAY_W   = 7;
  localparam int TABLE_W   = SLOTS * DELAY_W;
  localparam int DIVISOR_W = 14;   // delay * 100 fits below 2**14

  localparam logic [DIVISOR_W-1:0] DELAY_SCALE = DIVISOR_W'(100);

  // x / 10 == (x * 52429) >> 19 for every x below 2**16
  localparam int          RECIP_SH = 19;
  localparam logic [16:0] RECIP10  = 17'd52429;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALL = CFG_IDX_W'(1);

endpackage

@@ sv/ssrl_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on nothing; instantiated by servo_slew_rate_limiter.
module ssrl_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // dividend shifts out of the top of quo_q while quotient bits shift in below
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? DIVISOR_W'(trial - {1'b0, den_q}) : trial[DIVISOR_W-1:0];
    quo_d = {quo_q[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/servo_slew_rate_limiter.sv @@
// Top level of the per-channel servo slew-rate limiter.
// Depends on ssrl_pkg and ssrl_div.
//
//  channel   direction  payload (low bit first)                  transfer when
//  s_axis    in         tdata: channel[2:0], target[14:3]        tvalid & tready
//  m_axis    out        tdata: out_channel[2:0], position[14:3]  tvalid & tready
//  cfg       in         cfg_index_i, cfg_data_i                  cfg_valid_i & cfg_ready_o
//
// A limited move runs through S_DIV, where the bit-serial step divider works, then
// S_ABS, S_MUL and S_OUT; a jump or an out-of-range channel goes straight to S_OUT.
// One item is in work at a time; s_axis is ready again once the result sits in
// the output register, so a stalled m_axis holds up at most the following item.
// Reset clears all kept positions and both delay tables; no clearing pass.
module servo_slew_rate_limiter
  import ssrl_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int VALUE_LIMIT = VALUE_LIMIT_DEF,
  parameter int FRAME_US    = FRAME_US_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // channel[2:0], target[14:3]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // out_channel[2:0], position[14:3]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TABLE_W-1:0]   cfg_data_i
);

  localparam int TRAVEL   = (2 * VALUE_LIMIT * 10 * FRAME_US) / 1000;
  localparam int TRAVEL_W = $clog2(TRAVEL + 1);
  localparam int SUM_W    = ((TRAVEL_W > POS_W) ? TRAVEL_W : POS_W) + 2;
  localparam int NSLOT    = (CHANNELS > SLOTS) ? SLOTS : CHANNELS;
  localparam int SLOT_W   = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ABS,
    S_MUL,
    S_OUT
  } state_e;

  state_e state_q;

  logic [TABLE_W-1:0] rise_q, fall_q;

  logic signed [POS_W-1:0] pos_mem_q [NSLOT];

  logic                     accept;
  logic [CH_W-1:0]          in_ch;
  logic [TGT_W-1:0]         in_tgt;
  logic signed [POS_W-1:0]  tgt_ext, tgt10, pos_rd;
  logic                     in_range;
  logic [DELAY_W-1:0]       rise_sel, fall_sel;
  logic                     go_up, go_dn;

  logic [CH_W-1:0]          ch_q;
  logic [TGT_W-1:0]         res_q;
  logic signed [POS_W-1:0]  tgt10_q, pos_q, pos_new_q;
  logic                     up_q, wr_q, neg_q;
  logic [POS_W-1:0]         mag_q;
  logic                     m_valid_q;
  logic [DATA_W-1:0]        m_data_q;

  logic                     div_start, div_done;
  logic [DIVISOR_W-1:0]     div_den;
  logic [TRAVEL_W-1:0]      step;

  logic signed [SUM_W-1:0]  pos_w, tgt_w, step_w, sum_w, lim_w;
  logic [32:0]              prod;
  logic [POS_W-1:0]         quot;
  logic                     out_free;

  // input decode, position read and direction pick in the transfer cycle
  always_comb begin
    accept   = s_axis_tvalid && s_axis_tready;
    in_ch    = s_axis_tdata[CH_W-1:0];
    in_tgt   = s_axis_tdata[CH_W +: TGT_W];
    tgt_ext  = {{(POS_W-TGT_W){in_tgt[TGT_W-1]}}, in_tgt};
    tgt10    = (tgt_ext <<< 3) + (tgt_ext <<< 1);
    in_range = {1'b0, in_ch} < (CH_W+1)'(CHANNELS);
    pos_rd   = in_range ? pos_mem_q[in_ch[SLOT_W-1:0]] : '0;
    rise_sel = rise_q[DELAY_W*in_ch +: DELAY_W];
    fall_sel = fall_q[DELAY_W*in_ch +: DELAY_W];
    go_up    = in_range && (rise_sel != '0) && (tgt10 > pos_rd);
    go_dn    = in_range && !go_up && (fall_sel != '0) && (tgt10 < pos_rd);
    div_start = accept && (go_up || go_dn);
    div_den   = DIVISOR_W'(go_up ? rise_sel : fall_sel) * DELAY_SCALE;
  end

  ssrl_div #(
    .DIVIDEND_W(TRAVEL_W),
    .DIVISOR_W (DIVISOR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(TRAVEL_W'(TRAVEL)),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(step)
  );

  // step and clamp, formed wide so the sum cannot wrap; magnitude divided by ten
  always_comb begin
    pos_w  = {{(SUM_W-POS_W){pos_q[POS_W-1]}}, pos_q};
    tgt_w  = {{(SUM_W-POS_W){tgt10_q[POS_W-1]}}, tgt10_q};
    step_w = {{(SUM_W-TRAVEL_W){1'b0}}, step};
    sum_w  = up_q ? pos_w + step_w : pos_w - step_w;
    if (up_q) begin
      lim_w = (sum_w > tgt_w) ? tgt_w : sum_w;
    end else begin
      lim_w = (sum_w < tgt_w) ? tgt_w : sum_w;
    end
    prod = 33'(mag_q) * 33'(RECIP10);
    quot = POS_W'(prod >> RECIP_SH);
  end

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      rise_q    <= '0;
      fall_q    <= '0;
      for (int i = 0; i < NSLOT; i++) begin
        pos_mem_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RISE: rise_q <= cfg_data_i;
          REG_FALL: fall_q <= cfg_data_i;
          default:  ;
        endcase
      end
      // in S_OUT the valid flag is reloaded below
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= (go_up || go_dn) ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_ABS;
          end
        end
        S_ABS: state_q <= S_MUL;
        S_MUL: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            if (wr_q) begin
              pos_mem_q[ch_q[SLOT_W-1:0]] <= pos_new_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ch_q      <= in_ch;
          tgt10_q   <= tgt10;
          pos_q     <= pos_rd;
          up_q      <= go_up;
          wr_q      <= in_range;
          res_q     <= in_tgt;     // jump result, overwritten when limited
          pos_new_q <= tgt10;
        end
      end
      S_DIV: begin
        if (div_done) begin
          pos_new_q <= POS_W'(lim_w);
        end
      end
      S_ABS: begin
        neg_q <= pos_new_q[POS_W-1];
        mag_q <= pos_new_q[POS_W-1] ? POS_W'(-pos_new_q) : POS_W'(pos_new_q);
      end
      S_MUL: begin
        res_q <= neg_q ? TGT_W'(-quot) : TGT_W'(quot);
      end
      S_OUT: begin
        if (out_free) begin
          m_data_q <= {{(DATA_W-CH_W-TGT_W){1'b0}}, res_q, ch_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule
